FILE: hw/rtl/merge_sort_engine_assert.svh
// Assertion macros for the merge sort engine checker.
// Needs nothing else; included by the checker file only.
`ifndef MERGE_SORT_ENGINE_ASSERT_SVH
`define MERGE_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define MSE_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("merge sort engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define MSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("merge sort engine: next-cycle check failed");

`endif

FILE: hw/rtl/mse_pkg.sv
// Shared types and defaults for the merge sort engine.
// Used by the controller, the datapath and the top level.
package mse_pkg;

  localparam int MSE_CAPACITY   = 64;
  localparam int MSE_DATA_WIDTH = 32;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_MERGE,
    ST_EMIT_RD,
    ST_EMIT_WR
  } mse_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;     // input item taken this cycle
    logic start;      // accepted item is the last of the set
    logic setup;      // initialise pointers for a new pass
    logic step;       // merge one element
    logic emit_addr;  // read port 0 follows the emit index
    logic emit_load;  // load the output register
  } mse_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic store_empty;  // no element held yet
    logic pass_end;     // this step writes the final element of the pass
    logic last_pass;    // the current pass is the final one
    logic emit_last;    // the emit index points at the final element
    logic out_free;     // output register can take an item this cycle
  } mse_status_t;

endpackage

FILE: hw/rtl/mse_controller.sv
// Sequencer for the merge sort engine: load, merge passes, emission.
// Depends on mse_pkg for state, command and status types.
module mse_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                is_last,
  input  mse_pkg::mse_status_t status,
  output mse_pkg::mse_cmd_t    cmd,
  output logic                in_stall
);
  import mse_pkg::*;

  mse_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_valid && is_last) begin
          state_next = status.store_empty ? ST_EMIT_RD : ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (status.pass_end) begin
          state_next = status.last_pass ? ST_EMIT_RD : ST_SETUP;
        end
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (status.out_free) begin
          state_next = status.emit_last ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_LOAD: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        cmd.start  = in_valid && is_last;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ST_MERGE: begin
        cmd.step = 1'b1;
      end
      ST_EMIT_RD: begin
        cmd.emit_addr = 1'b1;
      end
      ST_EMIT_WR: begin
        cmd.emit_addr = 1'b1;
        cmd.emit_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/mse_datapath.sv
// Datapath of the merge sort engine: two ping-pong element memories,
// run pointers, the merge compare and the output register. Uses mse_pkg.
module mse_datapath #(
  parameter int CAPACITY   = mse_pkg::MSE_CAPACITY,
  parameter int DATA_WIDTH = mse_pkg::MSE_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mse_pkg::mse_cmd_t            cmd,
  output mse_pkg::mse_status_t         status,
  input  logic signed [DATA_WIDTH-1:0] value,
  output logic signed [DATA_WIDTH-1:0] sorted_value,
  output logic                         end_of_set,
  output logic                         dropped,
  output logic                         out_valid,
  input  logic                         out_stall
);
  import mse_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int SUM_W  = CNT_W + 2;

  // Element memories; the source of a pass alternates between them
  logic signed [DATA_WIDTH-1:0] mem_a [CAPACITY];
  logic signed [DATA_WIDTH-1:0] mem_b [CAPACITY];
  logic signed [DATA_WIDTH-1:0] rd_a0, rd_a1, rd_b0, rd_b1;

  logic [CNT_W-1:0] count;
  logic             overflow;
  logic [CNT_W:0]   width;
  logic             src_b;
  logic [CNT_W-1:0] i, j, mid, hi, k, e;
  logic [CNT_W-1:0] i_next, j_next, mid_next, hi_next, k_next;

  logic signed [DATA_WIDTH-1:0] d0, d1, merge_data;
  logic             take_left, pair_end, pass_end;
  logic [CNT_W-1:0] k_inc, e_inc;
  logic [SUM_W-1:0] count_s, width_s, width_2s, hi_w, hi_2w;
  logic [CNT_W-1:0] mid_pair, hi_pair, mid_init, hi_init;
  logic [ADDR_W-1:0] ra0, ra1;
  logic             store_room, out_free;

  assign count_s    = SUM_W'(count);
  assign width_s    = SUM_W'(width);
  assign width_2s   = width_s << 1;
  assign store_room = count < CNT_W'(CAPACITY);
  assign out_free   = !out_valid || !out_stall;

  // Select the source memory's read data
  assign d0 = src_b ? rd_b0 : rd_a0;
  assign d1 = src_b ? rd_b1 : rd_a1;

  // Compare the two run heads; ties take the left run
  assign take_left  = (i < mid) && ((j >= hi) || (d0 <= d1));
  assign merge_data = take_left ? d0 : d1;
  assign k_inc      = k + CNT_W'(1);
  assign e_inc      = e + CNT_W'(1);
  assign pair_end   = k_inc == hi;
  assign pass_end   = k_inc == count;

  // Bounds of the next run pair, clamped to the set size
  assign hi_w  = SUM_W'(hi) + width_s;
  assign hi_2w = SUM_W'(hi) + (width_s << 1);
  always_comb begin
    mid_pair = (hi_w > count_s) ? count : hi_w[CNT_W-1:0];
    hi_pair  = (hi_2w > count_s) ? count : hi_2w[CNT_W-1:0];
    mid_init = (width_s > count_s) ? count : width_s[CNT_W-1:0];
    hi_init  = (width_2s > count_s) ? count : width_2s[CNT_W-1:0];
  end

  // Advance the run pointers
  always_comb begin
    i_next   = i;
    j_next   = j;
    mid_next = mid;
    hi_next  = hi;
    k_next   = k;
    if (cmd.setup) begin
      i_next   = '0;
      mid_next = mid_init;
      j_next   = mid_init;
      hi_next  = hi_init;
      k_next   = '0;
    end else if (cmd.step) begin
      k_next = k_inc;
      if (pair_end) begin
        i_next   = hi;
        mid_next = mid_pair;
        j_next   = mid_pair;
        hi_next  = hi_pair;
      end else if (take_left) begin
        i_next = i + CNT_W'(1);
      end else begin
        j_next = j + CNT_W'(1);
      end
    end
  end

  // Read addresses follow the next heads, or the emit index
  assign ra0 = cmd.emit_addr ? e[ADDR_W-1:0] : i_next[ADDR_W-1:0];
  assign ra1 = j_next[ADDR_W-1:0];

  // Memory A: loaded from the input, or a merge destination
  always_ff @(posedge clk) begin
    if (cmd.accept && store_room) begin
      mem_a[count[ADDR_W-1:0]] <= value;
    end else if (cmd.step && src_b) begin
      mem_a[k[ADDR_W-1:0]] <= merge_data;
    end
    rd_a0 <= mem_a[ra0];
    rd_a1 <= mem_a[ra1];
  end

  // Memory B: merge destination only
  always_ff @(posedge clk) begin
    if (cmd.step && !src_b) begin
      mem_b[k[ADDR_W-1:0]] <= merge_data;
    end
    rd_b0 <= mem_b[ra0];
    rd_b1 <= mem_b[ra1];
  end

  // Pointer registers
  always_ff @(posedge clk) begin
    i   <= i_next;
    j   <= j_next;
    mid <= mid_next;
    hi  <= hi_next;
    k   <= k_next;
  end

  // Fill count, overflow flag, pass width, source select and emit index
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      width    <= '0;
      src_b    <= 1'b0;
      e        <= '0;
    end else begin
      if (cmd.accept) begin
        if (store_room) begin
          count <= count + CNT_W'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.start) begin
        width <= (CNT_W + 1)'(1);
        src_b <= 1'b0;
        e     <= '0;
      end
      if (cmd.step && pass_end) begin
        width <= width << 1;
        src_b <= !src_b;
      end
      if (cmd.emit_load) begin
        e <= e_inc;
        if (status.emit_last) begin
          count    <= '0;
          overflow <= 1'b0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      sorted_value <= d0;
      end_of_set   <= status.emit_last;
      dropped      <= status.emit_last && overflow;
    end
  end

  // Status back to the controller
  always_comb begin
    status.store_empty = count == '0;
    status.pass_end    = pass_end;
    status.last_pass   = (width_s << 1) >= count_s;
    status.emit_last   = e_inc == count;
    status.out_free    = out_free;
  end

endmodule

FILE: hw/rtl/merge_sort_engine.sv
// Merge sort engine: loads one item per cycle while in the load state; after
// the last item it stalls input and runs ceil(log2 n) merge passes over the
// ping-pong memories. Emission reads each result from memory, then loads the
// output register, waiting while the output is stalled.
// Synchronous reset clears control state but not the run pointers; memories are not cleared.
// Top level: controller and datapath joined by command and status structs.
module merge_sort_engine #(
  parameter int CAPACITY   = mse_pkg::MSE_CAPACITY,
  parameter int DATA_WIDTH = mse_pkg::MSE_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic                         is_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] sorted_value,
  output logic                         end_of_set,
  output logic                         dropped
);
  import mse_pkg::*;

  mse_cmd_t    cmd;
  mse_status_t status;

  mse_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .is_last  (is_last),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  mse_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .value        (value),
    .sorted_value (sorted_value),
    .end_of_set   (end_of_set),
    .dropped      (dropped),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

endmodule

FILE: hw/rtl/mse_checker.sv
// Port-level checks for the merge sort engine, and the bind that attaches
// them. Depends on merge_sort_engine_assert.svh for the assertion macros.
`include "merge_sort_engine_assert.svh"

module mse_checker #(
  parameter int DATA_WIDTH = mse_pkg::MSE_DATA_WIDTH
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         is_last,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [DATA_WIDTH-1:0] sorted_value,
  input logic                         end_of_set,
  input logic                         dropped
);

  // Overflow is reported only on the final item of a set
  `MSE_ASSERT_SAME(a_drop_final, clk, rst, out_valid && dropped, end_of_set)

  // The last item of a set starts the sort, so input stalls next cycle
  `MSE_ASSERT_NEXT(a_stall_after_last, clk, rst, in_valid && !in_stall && is_last, in_stall)

  // Hold a stalled result
  `MSE_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(sorted_value) && $stable(end_of_set) && $stable(dropped))

endmodule

bind merge_sort_engine mse_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_mse_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .is_last      (is_last),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .sorted_value (sorted_value),
  .end_of_set   (end_of_set),
  .dropped      (dropped)
);
